@@ rtl/periodic_phase_first_index_top_macros.svh @@
// Assertion macros shared by the checker of periodic_phase_first_index_top.
// Needs signals clk and arst_n in the including scope.
`ifndef PERIODIC_PHASE_FIRST_INDEX_TOP_MACROS_SVH
`define PERIODIC_PHASE_FIRST_INDEX_TOP_MACROS_SVH

// same-cycle implication
`define PPFI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppfi check failed");

// next-cycle implication
`define PPFI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppfi check failed");

`endif

@@ rtl/ppfi_pkg.sv @@
// Types and constants of the periodic phase first index block.
// No dependencies.
package ppfi_pkg;

	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [31:0] period_len;
		logic [31:0] start_phase;
		logic [31:0] stride;
		logic [31:0] target_phase;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] first_idx;
	} rsp_t;

	// division jobs of the shared divider
	typedef enum logic [2:0] {
		DOP_GCD  = 3'd0,
		DOP_DIFF = 3'd1,
		DOP_PER  = 3'd2,
		DOP_STR  = 3'd3,
		DOP_RED  = 3'd4,
		DOP_INV  = 3'd5,
		DOP_FIN  = 3'd6
	} dop_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MSEL_Q = 2'd0,
		MSEL_K = 2'd1,
		MSEL_S = 2'd2
	} msel_t;

	typedef struct packed {
		logic        capture;
		logic        gcd_init;
		logic        div_start;
		logic        div_take;
		dop_t        dop;
		logic        mul_en;
		msel_t       msel;
		logic        inv_upd;
		logic        res_set;
		logic [1:0]  res;
		logic        out_load;
	} cmd_t;

	typedef struct packed {
		logic req_valid;
		logic range_bad;
		logic ph_eq;
		logic b_zero;
		logic div_done;
		logic rem_nz;
		logic perd_lt2;
		logic rlo_zero;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/ppfi_div.sv @@
// Restoring divider, one quotient bit per cycle, narrow or wide dividend.
// Depends on nothing.
module ppfi_div #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           wide,
	input  logic [2*W-1:0] dividend,
	input  logic [W-1:0]   divisor,
	output logic           done,
	output logic [2*W-1:0] quo,
	output logic [W-1:0]   rem
);
	localparam int CW = $clog2(2*W+1);

	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W-1:0]   rem_q;
	logic [2*W-1:0] quo_q;
	logic [W-1:0]   dvs_q;
	logic [W:0]     shifted;
	logic [W:0]     diff;
	logic           fits;

	// trial subtract of the next bit
	assign shifted = {rem_q, quo_q[2*W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = (shifted >= {1'b0, dvs_q});

	// control: count iterations, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= wide ? CW'(2*W) : CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in a bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= wide ? dividend : {dividend[W-1:0], {W{1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[2*W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

@@ rtl/ppfi_dp.sv @@
// Datapath: operand registers, shared divider, shared multiplier, result register.
// Depends on ppfi_pkg and ppfi_div.
module ppfi_dp import ppfi_pkg::*; #(
	parameter int W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  req_t req,
	input  logic req_valid,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	logic [W-1:0]     period_q, ph0_q, stride_q, ph_q;
	logic [W-1:0]     a_q, b_q;
	logic [W-1:0]     diffd_q, perd_q, strd_q;
	logic [W-1:0]     rhi_q, rlo_q, q_q, k0_q;
	logic [W:0]       cold_q, cnew_q;
	logic [2*W-1:0]   mul_q;
	logic [1:0]       res_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [W:0]       diff_w;
	logic [W:0]       inv_w;
	logic [2*W-1:0]   dvd;
	logic [W-1:0]     dvs;
	logic             dv_done;
	logic [2*W-1:0]   dv_quo;
	logic [W-1:0]     dv_rem;
	logic signed [W+1:0]   ma, mb;
	logic signed [2*W+3:0] prod;

	// phase difference around the cycle
	assign diff_w = (ph_q >= ph0_q) ? ({1'b0, ph_q} - {1'b0, ph0_q})
	                                : ({1'b0, ph_q} + {1'b0, period_q} - {1'b0, ph0_q});
	// fold the negative coefficient into range
	assign inv_w = cold_q[W] ? (cold_q + {1'b0, perd_q}) : cold_q;

	// divider operand selection
	always_comb begin
		dvd = '0;
		dvs = '0;
		case (cmd.dop)
			DOP_GCD:  begin dvd = {{W{1'b0}}, a_q};          dvs = b_q;    end
			DOP_DIFF: begin dvd = {{W{1'b0}}, diff_w[W-1:0]}; dvs = a_q;    end
			DOP_PER:  begin dvd = {{W{1'b0}}, period_q};     dvs = a_q;    end
			DOP_STR:  begin dvd = {{W{1'b0}}, stride_q};     dvs = a_q;    end
			DOP_RED:  begin dvd = {{W{1'b0}}, strd_q};       dvs = perd_q; end
			DOP_INV:  begin dvd = {{W{1'b0}}, rhi_q};        dvs = rlo_q;  end
			DOP_FIN:  begin dvd = mul_q;                     dvs = perd_q; end
			default:  begin dvd = '0;                        dvs = '0;     end
		endcase
	end

	ppfi_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.wide     (cmd.dop == DOP_FIN),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (dv_done),
		.quo      (dv_quo),
		.rem      (dv_rem)
	);

	// multiplier operand selection
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.msel)
			MSEL_Q: begin ma = {2'b00, q_q};   mb = {cnew_q[W], cnew_q};       end
			MSEL_K: begin ma = {2'b00, diffd_q}; mb = {2'b00, inv_w[W-1:0]}; end
			MSEL_S: begin ma = {2'b00, k0_q};  mb = {2'b00, stride_q};         end
			default: begin ma = '0;            mb = '0;                        end
		endcase
	end
	assign prod = ma * mb;

	// operand and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			period_q <= req.period_len[W-1:0];
			ph0_q    <= req.start_phase[W-1:0];
			stride_q <= req.stride[W-1:0];
			ph_q     <= req.target_phase[W-1:0];
			mul_q    <= '0;
		end
		if (cmd.gcd_init) begin
			a_q <= stride_q;
			b_q <= period_q;
		end
		if (cmd.div_take) begin
			case (cmd.dop)
				DOP_GCD:  begin a_q <= b_q; b_q <= dv_rem; end
				DOP_DIFF: diffd_q <= dv_quo[W-1:0];
				DOP_PER:  perd_q  <= dv_quo[W-1:0];
				DOP_STR:  strd_q  <= dv_quo[W-1:0];
				DOP_RED:  begin
					rhi_q  <= perd_q;
					rlo_q  <= dv_rem;
					cold_q <= '0;
					cnew_q <= (W+1)'(1);
				end
				DOP_INV:  begin
					q_q   <= dv_quo[W-1:0];
					rhi_q <= rlo_q;
					rlo_q <= dv_rem;
				end
				DOP_FIN:  k0_q <= dv_rem;
				default:  ;
			endcase
		end
		if (cmd.mul_en) begin
			mul_q <= prod[2*W-1:0];
		end
		// advance the Bezout coefficients
		if (cmd.inv_upd) begin
			cold_q <= cnew_q;
			cnew_q <= cold_q - mul_q[W:0];
		end
		if (cmd.res_set) begin
			res_q <= cmd.res;
		end
		if (cmd.out_load) begin
			rsp_q.status    <= res_q;
			rsp_q.first_idx <= (res_q == ST_FOUND) ? 64'(mul_q) : 64'd0;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.req_valid = req_valid;
	assign sts.range_bad = (ph0_q >= period_q) || (ph_q >= period_q);
	assign sts.ph_eq     = (ph0_q == ph_q);
	assign sts.b_zero    = (b_q == '0);
	assign sts.div_done  = dv_done;
	assign sts.rem_nz    = (dv_rem != '0);
	assign sts.perd_lt2  = (perd_q < W'(2));
	assign sts.rlo_zero  = (rlo_q == '0);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

@@ rtl/ppfi_ctrl.sv @@
// Controller: sequences gcd, reductions, inverse loop and final scaling.
// Depends on ppfi_pkg.
module ppfi_ctrl import ppfi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd,
	output logic idle
);
	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_CHECK = 14'b00000000000010,
		S_GCD   = 14'b00000000000100,
		S_DIFF  = 14'b00000000001000,
		S_PER   = 14'b00000000010000,
		S_STR   = 14'b00000000100000,
		S_RED   = 14'b00000001000000,
		S_INV   = 14'b00000010000000,
		S_INVM  = 14'b00000100000000,
		S_INVU  = 14'b00001000000000,
		S_MULI  = 14'b00010000000000,
		S_FIN   = 14'b00100000000000,
		S_SCALE = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   issued_q, issued_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= issued_d;
		end
	end

	// next state and commands
	always_comb begin
		cmd      = '0;
		cmd.dop  = DOP_GCD;
		cmd.msel = MSEL_Q;
		state_d  = state_q;
		issued_d = issued_q;
		case (state_q)
			S_IDLE: begin
				if (sts.req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.range_bad) begin
					cmd.res_set = 1'b1;
					cmd.res     = ST_RANGE;
					state_d     = S_OUT;
				end else if (sts.ph_eq) begin
					cmd.res_set = 1'b1;
					cmd.res     = ST_FOUND;
					state_d     = S_OUT;
				end else begin
					cmd.gcd_init = 1'b1;
					state_d      = S_GCD;
				end
			end
			S_GCD: begin
				cmd.dop = DOP_GCD;
				if (!issued_q) begin
					if (sts.b_zero) begin
						state_d = S_DIFF;
					end else begin
						cmd.div_start = 1'b1;
						issued_d      = 1'b1;
					end
				end else if (sts.div_done) begin
					cmd.div_take = 1'b1;
					issued_d     = 1'b0;
				end
			end
			S_DIFF: begin
				cmd.dop = DOP_DIFF;
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_d      = 1'b1;
				end else if (sts.div_done) begin
					cmd.div_take = 1'b1;
					issued_d     = 1'b0;
					if (sts.rem_nz) begin
						cmd.res_set = 1'b1;
						cmd.res     = ST_NONE;
						state_d     = S_OUT;
					end else begin
						state_d = S_PER;
					end
				end
			end
			S_PER, S_STR: begin
				cmd.dop = (state_q == S_PER) ? DOP_PER : DOP_STR;
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_d      = 1'b1;
				end else if (sts.div_done) begin
					cmd.div_take = 1'b1;
					issued_d     = 1'b0;
					state_d      = (state_q == S_PER) ? S_STR : S_RED;
				end
			end
			S_RED: begin
				cmd.dop = DOP_RED;
				if (!issued_q) begin
					if (sts.perd_lt2) begin
						cmd.res_set = 1'b1;
						cmd.res     = ST_NONE;
						state_d     = S_OUT;
					end else begin
						cmd.div_start = 1'b1;
						issued_d      = 1'b1;
					end
				end else if (sts.div_done) begin
					cmd.div_take = 1'b1;
					issued_d     = 1'b0;
					state_d      = S_INV;
				end
			end
			S_INV: begin
				cmd.dop = DOP_INV;
				if (!issued_q) begin
					if (sts.rlo_zero) begin
						state_d = S_MULI;
					end else begin
						cmd.div_start = 1'b1;
						issued_d      = 1'b1;
					end
				end else if (sts.div_done) begin
					cmd.div_take = 1'b1;
					issued_d     = 1'b0;
					state_d      = S_INVM;
				end
			end
			S_INVM: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MSEL_Q;
				state_d    = S_INVU;
			end
			S_INVU: begin
				cmd.inv_upd = 1'b1;
				state_d     = S_INV;
			end
			S_MULI: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MSEL_K;
				state_d    = S_FIN;
			end
			S_FIN: begin
				cmd.dop = DOP_FIN;
				if (!issued_q) begin
					cmd.div_start = 1'b1;
					issued_d      = 1'b1;
				end else if (sts.div_done) begin
					cmd.div_take = 1'b1;
					issued_d     = 1'b0;
					state_d      = S_SCALE;
				end
			end
			S_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MSEL_S;
				cmd.res_set = 1'b1;
				cmd.res     = ST_FOUND;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d  = S_IDLE;
				issued_d = 1'b0;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
endmodule

@@ rtl/periodic_phase_first_index_top.sv @@
// Out-of-range and equal-phase items go straight to the output; other items take
// G gcd rounds and I inverse rounds on the shared divider, which yields one
// quotient bit per cycle while busy (W = OPERAND_WIDTH bits per operand).
// Throughput: one item at a time; the next item enters once the result moves
// to the output register. Reset clears the controller and the output valid.
module periodic_phase_first_index_top import ppfi_pkg::*; #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	cmd_t cmd;
	sts_t sts;
	logic idle;

	ppfi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd),
		.idle   (idle)
	);

	ppfi_dp #(.W(OPERAND_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.req_valid (req_valid),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// take a new item only between items
	assign req_stall = !idle;
endmodule

@@ rtl/ppfi_chk.sv @@
// Port-level checks of periodic_phase_first_index_top, with its bind.
// Depends on ppfi_pkg and the macros header.
`include "periodic_phase_first_index_top_macros.svh"
module ppfi_chk import ppfi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);
	`PPFI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
	`PPFI_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
	`PPFI_ASSERT_NOW(a_status_code, rsp_valid, rsp.status != 2'd3)
	`PPFI_ASSERT_NOW(a_idx_zero, rsp_valid && (rsp.status != ST_FOUND), rsp.first_idx == 64'd0)
endmodule

bind periodic_phase_first_index_top ppfi_chk u_chk (.*);
